/* src/joint_command_softstop_packer_assert.svh */
`ifndef JOINT_COMMAND_SOFTSTOP_PACKER_ASSERT_SVH
`define JOINT_COMMAND_SOFTSTOP_PACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define JCSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jcsp: same-cycle check failed");

// next-cycle implication
`define JCSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jcsp: next-cycle check failed");

`endif

/* src/jcsp_pkg.sv */
`timescale 1ns / 1ps
package jcsp_pkg;

	// quantizer widths
	localparam int POSITION_BITS_DEF = 16;
	localparam int FIELD_BITS_DEF    = 12;

	// frame slots
	localparam int FRAME_W      = 64;
	localparam int POS_SLOT_W   = 16;
	localparam int FIELD_SLOT_W = 12;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;
	localparam logic [CFG_IDX_W-1:0] CFG_SOFT_LIMIT_UPPER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOFT_LIMIT_LOWER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOFTSTOP_STIFFNESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOFTSTOP_DAMPING   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SOFTSTOP_ENABLE    = 3'd4;

	localparam int LIMIT_W = 21;
	localparam int STIFF_W = 25;
	localparam int DAMP_W  = 21;

	localparam logic signed [LIMIT_W-1:0] UPPER_RST  = 21'sd55706;
	localparam logic signed [LIMIT_W-1:0] LOWER_RST  = -21'sd280494;
	localparam logic [STIFF_W-1:0]        STIFF_RST  = 25'd29491200;
	localparam logic [DAMP_W-1:0]         DAMP_RST   = 21'd327680;
	localparam logic                      ENABLE_RST = 1'b1;

	// each span is DIV * 2**SHIFT
	localparam int P_DIV  = 25;
	localparam int P_SHIFT = 16;
	localparam int V_DIV  = 30;
	localparam int V_SHIFT = 17;
	localparam int KP_DIV = 500;
	localparam int KP_SHIFT = 16;
	localparam int KD_DIV = 20;
	localparam int KD_SHIFT = 16;
	localparam int T_DIV  = 40;
	localparam int T_SHIFT = 17;

	localparam int P_SPAN  = P_DIV << P_SHIFT;
	localparam int V_SPAN  = V_DIV << V_SHIFT;
	localparam int KP_SPAN = KP_DIV << KP_SHIFT;
	localparam int KD_SPAN = KD_DIV << KD_SHIFT;
	localparam int T_SPAN  = T_DIV << T_SHIFT;

	localparam int P_LIM = P_SPAN / 2;
	localparam int V_LIM = V_SPAN / 2;
	localparam int T_LIM = T_SPAN / 2;

	localparam int P_OFF_W   = $clog2(P_SPAN + 1);
	localparam int V_OFF_W   = $clog2(V_SPAN + 1);
	localparam int KP_OFF_W  = $clog2(KP_SPAN + 1);
	localparam int KD_OFF_W  = $clog2(KD_SPAN + 1);
	localparam int T_OFF_W   = $clog2(T_SPAN + 1);
	localparam int OFF_MAX_W = KP_OFF_W;

	// soft-stop arithmetic
	localparam int VAL_W      = 32;
	localparam int DIFF_W     = 33;
	localparam int DIFF_LO_W  = 17;
	localparam int PROD_LO_W  = STIFF_W + DIFF_LO_W;
	localparam int PROD_HI_W  = STIFF_W + 1 + DIFF_W - DIFF_LO_W;
	localparam int Q_FRAC     = 16;
	localparam int TSUM_W     = 44;

	localparam logic [FRAME_W-1:0] ENTER_FRAME = 64'hFFFF_FFFF_FFFF_FFFC;
	localparam logic [FRAME_W-1:0] EXIT_FRAME  = 64'hFFFF_FFFF_FFFF_FFFD;

	localparam logic [1:0] KIND_COMMAND = 2'd0;
	localparam logic [1:0] KIND_ENTER   = 2'd1;
	localparam logic [1:0] KIND_EXIT    = 2'd2;

	localparam logic [1:0] STATUS_NORMAL   = 2'd0;
	localparam logic [1:0] STATUS_SOFTSTOP = 2'd1;
	localparam logic [1:0] STATUS_ESTOP    = 2'd2;
	localparam logic [1:0] STATUS_MODE     = 2'd3;

	typedef struct packed {
		logic signed [VAL_W-1:0] measured_position;
		logic signed [VAL_W-1:0] target_position;
		logic signed [VAL_W-1:0] target_velocity;
		logic signed [VAL_W-1:0] stiffness_gain;
		logic signed [VAL_W-1:0] damping_gain;
		logic signed [VAL_W-1:0] feedforward_torque;
		logic                    enable_request;
		logic                    estop_active;
	} jcsp_in_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [1:0]         frame_kind;
		logic [1:0]         status;
		logic               last;
	} jcsp_out_t;

	typedef struct packed {
		logic load_in;
		logic en_mul;
		logic en_sum;
		logic en_recip;
		logic load_mode;
		logic load_repeat;
		logic load_cmd;
	} jcsp_cmd_t;

	typedef struct packed {
		logic mode_change;
	} jcsp_sts_t;

endpackage

/* src/joint_command_softstop_packer.sv */
`timescale 1ns / 1ps
// Joint command packer with soft stop.
// in channel (in_valid/in_ready/in_data): one joint command plus the latest
// measured position, all Q16.16. out channel (out_valid/out_ready/out_data):
// 64-bit command frames with kind, status and a last flag.
// cfg port (cfg_we/cfg_index/cfg_data): soft-stop limits and gains, registered
// while cfg_we is high; write only while no command is in flight.
// A command beat runs through these steps: accept with limit test, overshoot multiply,
// sum and clamp, reciprocal quantize, then the frame lands in the output
// register. The next beat is taken in the same cycle the frame is loaded; no
// new command is accepted while one is still in the earlier steps.
// A change of enable_request yields two beats (mode frame, then the stored
// last frame, last=1) from ST_MODE then ST_REPEAT; the command itself is dropped.
// If the receiver stalls, the frame waits in the output register and the
// engine holds in its final step; input stays closed until then.
// Reset: config regs return to their defaults, motor mode off, the stored
// frame becomes the encoding of the all-zero command, no beat pending.
module joint_command_softstop_packer #(
	parameter int POSITION_BITS = jcsp_pkg::POSITION_BITS_DEF,
	parameter int FIELD_BITS    = jcsp_pkg::FIELD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  jcsp_pkg::jcsp_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output jcsp_pkg::jcsp_out_t             out_data,
	input  logic                            cfg_we,
	input  logic [jcsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jcsp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import jcsp_pkg::*;

	jcsp_cmd_t cmd;
	jcsp_sts_t sts;

	jcsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	jcsp_datapath #(
		.POSITION_BITS (POSITION_BITS),
		.FIELD_BITS    (FIELD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

/* src/jcsp_ctrl.sv */
`timescale 1ns / 1ps
module jcsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  jcsp_pkg::jcsp_sts_t sts,
	output jcsp_pkg::jcsp_cmd_t cmd
);
	import jcsp_pkg::*;

	`include "joint_command_softstop_packer_assert.svh"

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_MODE   = 7'b0000010,
		ST_REPEAT = 7'b0000100,
		ST_MUL    = 7'b0001000,
		ST_SUM    = 7'b0010000,
		ST_RECIP  = 7'b0100000,
		ST_PACK   = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       rdy;
	logic       load_any;
	logic [2:0] loads;

	// output register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		rdy     = 1'b0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				rdy = 1'b1;
				if (in_valid) state_d = sts.mode_change ? ST_MODE : ST_MUL;
			end
			ST_MODE: begin
				if (out_free) begin
					cmd.load_mode = 1'b1;
					state_d       = ST_REPEAT;
				end
			end
			ST_REPEAT: begin
				if (out_free) begin
					cmd.load_repeat = 1'b1;
					rdy             = 1'b1;
					if (in_valid) state_d = sts.mode_change ? ST_MODE : ST_MUL;
					else state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.en_mul = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.en_sum = 1'b1;
				state_d    = ST_RECIP;
			end
			ST_RECIP: begin
				cmd.en_recip = 1'b1;
				state_d      = ST_PACK;
			end
			ST_PACK: begin
				if (out_free) begin
					cmd.load_cmd = 1'b1;
					rdy          = 1'b1;
					if (in_valid) state_d = sts.mode_change ? ST_MODE : ST_MUL;
					else state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.load_in = in_valid && rdy;
	end

	assign loads    = {cmd.load_mode, cmd.load_repeat, cmd.load_cmd};
	assign load_any = |loads;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_any) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = rdy;
	assign out_valid = out_valid_q;

	`JCSP_ASSERT_IMP(a_load_only_when_free, load_any, out_free)
	`JCSP_ASSERT_IMP(a_single_load, 1'b1, $onehot0(loads))
	`JCSP_ASSERT_NXT(a_mode_then_repeat, cmd.load_mode, state_q == ST_REPEAT)
	`JCSP_ASSERT_NXT(a_mul_then_sum, cmd.en_mul, cmd.en_sum)
	`JCSP_ASSERT_NXT(a_change_goes_mode, cmd.load_in && sts.mode_change, state_q == ST_MODE)

endmodule

/* src/jcsp_quant.sv */
`timescale 1ns / 1ps
module jcsp_quant #(
	parameter int BITS  = 12,
	parameter int OFF_W = 22,
	parameter int SHIFT = 17,
	parameter int DIV   = 30
) (
	input  logic             clk,
	input  logic             en,
	input  logic [OFF_W-1:0] off,
	output logic [BITS-1:0]  q
);
	// q = floor(off * (2**BITS - 1) / (DIV * 2**SHIFT))
	//   = floor(m / DIV) with m = floor(off * (2**BITS - 1) / 2**SHIFT)
	localparam int MW  = BITS + $clog2(DIV);
	localparam int SCW = OFF_W + BITS;
	localparam logic [MW-1:0] RECIP = MW'((longint'(1) << MW) / DIV);

	logic [SCW-1:0]  scaled;
	logic [MW-1:0]   m;
	logic [2*MW-1:0] prod;
	logic [MW-1:0]   m_s4;
	logic [BITS-1:0] q0_s4;
	logic [MW-1:0]   q0c;
	logic [MW-1:0]   rem;

	assign scaled = {off, BITS'(0)} - SCW'(off);
	assign m      = scaled[SHIFT +: MW];
	// truncated reciprocal: estimate is exact or one low
	assign prod   = (2*MW)'(m) * (2*MW)'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4  <= m;
			q0_s4 <= prod[MW +: BITS];
		end
	end

	assign q0c = MW'(MW'(q0_s4) * MW'(DIV));
	assign rem = m_s4 - q0c;
	assign q   = (rem >= MW'(DIV)) ? q0_s4 + BITS'(1) : q0_s4;

endmodule

/* src/jcsp_datapath.sv */
`timescale 1ns / 1ps
module jcsp_datapath #(
	parameter int POSITION_BITS = jcsp_pkg::POSITION_BITS_DEF,
	parameter int FIELD_BITS    = jcsp_pkg::FIELD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jcsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  jcsp_pkg::jcsp_in_t                in_data,
	input  jcsp_pkg::jcsp_cmd_t               cmd,
	output jcsp_pkg::jcsp_sts_t               sts,
	output jcsp_pkg::jcsp_out_t               out_data
);
	import jcsp_pkg::*;

	localparam logic [FRAME_W-1:0] LAST_RST = {
		POS_SLOT_W'((1 << (POSITION_BITS - 1)) - 1),
		FIELD_SLOT_W'((1 << (FIELD_BITS - 1)) - 1),
		FIELD_SLOT_W'(0),
		FIELD_SLOT_W'(0),
		FIELD_SLOT_W'((1 << (FIELD_BITS - 1)) - 1)
	};

	function automatic logic [OFF_MAX_W-1:0] clamp_off(
		input logic signed [TSUM_W-1:0] x,
		input logic signed [TSUM_W-1:0] lo,
		input logic signed [TSUM_W-1:0] hi
	);
		logic signed [TSUM_W-1:0] c;
		if (x < lo) c = lo;
		else if (x > hi) c = hi;
		else c = x;
		return OFF_MAX_W'(c - lo);
	endfunction

	// configuration
	logic signed [LIMIT_W-1:0] upper_q, lower_q;
	logic [STIFF_W-1:0]        stiff_q;
	logic [DAMP_W-1:0]         damp_q;
	logic                      ss_en_q;

	// machine state
	logic               motor_enabled_q;
	logic [FRAME_W-1:0] last_frame_q;

	// accept stage
	logic signed [DIFF_W-1:0] pos_ext, up_ext, lo_ext;
	logic                     hit_up, hit_lo, stop_hit;
	jcsp_in_t                 in_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic                     soft_s1;
	logic [1:0]               status_s1;

	// multiply stage
	logic [PROD_LO_W-1:0]        pl_s2;
	logic signed [PROD_HI_W-1:0] ph_s2;
	logic                        soft_s2;
	logic [1:0]                  status_s2;

	// sum and clamp stage
	logic signed [TSUM_W-1:0] pos_x, vel_x, kp_x, kd_x, tor_x, push;
	logic [P_OFF_W-1:0]       off_p_s3;
	logic [V_OFF_W-1:0]       off_v_s3;
	logic [KP_OFF_W-1:0]      off_kp_s3;
	logic [KD_OFF_W-1:0]      off_kd_s3;
	logic [T_OFF_W-1:0]       off_t_s3;
	logic [1:0]               status_s3;
	logic [1:0]               status_s4;

	logic [POSITION_BITS-1:0] q_p;
	logic [FIELD_BITS-1:0]    q_v, q_kp, q_kd, q_t;
	logic [FRAME_W-1:0]       packed_frame;
	jcsp_out_t                out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_RST;
			lower_q <= LOWER_RST;
			stiff_q <= STIFF_RST;
			damp_q  <= DAMP_RST;
			ss_en_q <= ENABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOFT_LIMIT_UPPER:   upper_q <= $signed(cfg_data[LIMIT_W-1:0]);
				CFG_SOFT_LIMIT_LOWER:   lower_q <= $signed(cfg_data[LIMIT_W-1:0]);
				CFG_SOFTSTOP_STIFFNESS: stiff_q <= cfg_data[STIFF_W-1:0];
				CFG_SOFTSTOP_DAMPING:   damp_q  <= cfg_data[DAMP_W-1:0];
				CFG_SOFTSTOP_ENABLE:    ss_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign sts.mode_change = in_data.enable_request != motor_enabled_q;

	// limit test and overshoot straight off the incoming beat
	assign pos_ext  = DIFF_W'(in_data.measured_position);
	assign up_ext   = DIFF_W'(upper_q);
	assign lo_ext   = DIFF_W'(lower_q);
	assign hit_up   = pos_ext >= up_ext;
	assign hit_lo   = pos_ext <= lo_ext;
	assign stop_hit = ss_en_q && !in_data.estop_active && (hit_up || hit_lo);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_s1   <= in_data;
			diff_s1 <= (hit_up ? up_ext : lo_ext) - pos_ext;
			soft_s1 <= stop_hit;
			if (in_data.estop_active) status_s1 <= STATUS_ESTOP;
			else if (stop_hit) status_s1 <= STATUS_SOFTSTOP;
			else status_s1 <= STATUS_NORMAL;
		end
	end

	// stiffness * overshoot in two partial products, low part unsigned
	always_ff @(posedge clk) begin
		if (cmd.en_mul) begin
			pl_s2     <= PROD_LO_W'(stiff_q) * PROD_LO_W'(diff_s1[DIFF_LO_W-1:0]);
			ph_s2     <= $signed({1'b0, stiff_q}) * $signed(diff_s1[DIFF_W-1:DIFF_LO_W]);
			soft_s2   <= soft_s1;
			status_s2 <= status_s1;
		end
	end

	// floor of the Q32.32 product to Q16.16: hi * 2**17 >> 16 is exact
	assign push = (TSUM_W'(ph_s2) <<< 1) + $signed(TSUM_W'(pl_s2[PROD_LO_W-1:Q_FRAC]));

	always_comb begin
		pos_x = TSUM_W'(in_s1.target_position);
		vel_x = TSUM_W'(in_s1.target_velocity);
		kp_x  = TSUM_W'(in_s1.stiffness_gain);
		kd_x  = TSUM_W'(in_s1.damping_gain);
		tor_x = TSUM_W'(in_s1.feedforward_torque);
		if (in_s1.estop_active) begin
			pos_x = '0;
			vel_x = '0;
			kp_x  = '0;
			kd_x  = '0;
			tor_x = '0;
		end else if (soft_s2) begin
			vel_x = '0;
			kp_x  = '0;
			kd_x  = $signed(TSUM_W'(damp_q));
			tor_x = tor_x + push;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en_sum) begin
			off_p_s3  <= P_OFF_W'(clamp_off(pos_x, TSUM_W'(-P_LIM), TSUM_W'(P_LIM)));
			off_v_s3  <= V_OFF_W'(clamp_off(vel_x, TSUM_W'(-V_LIM), TSUM_W'(V_LIM)));
			off_kp_s3 <= KP_OFF_W'(clamp_off(kp_x, TSUM_W'(0), TSUM_W'(KP_SPAN)));
			off_kd_s3 <= KD_OFF_W'(clamp_off(kd_x, TSUM_W'(0), TSUM_W'(KD_SPAN)));
			off_t_s3  <= T_OFF_W'(clamp_off(tor_x, TSUM_W'(-T_LIM), TSUM_W'(T_LIM)));
			status_s3 <= status_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en_recip) status_s4 <= status_s3;
	end

	jcsp_quant #(.BITS(POSITION_BITS), .OFF_W(P_OFF_W), .SHIFT(P_SHIFT), .DIV(P_DIV))
		u_quant_p (.clk(clk), .en(cmd.en_recip), .off(off_p_s3), .q(q_p));
	jcsp_quant #(.BITS(FIELD_BITS), .OFF_W(V_OFF_W), .SHIFT(V_SHIFT), .DIV(V_DIV))
		u_quant_v (.clk(clk), .en(cmd.en_recip), .off(off_v_s3), .q(q_v));
	jcsp_quant #(.BITS(FIELD_BITS), .OFF_W(KP_OFF_W), .SHIFT(KP_SHIFT), .DIV(KP_DIV))
		u_quant_kp (.clk(clk), .en(cmd.en_recip), .off(off_kp_s3), .q(q_kp));
	jcsp_quant #(.BITS(FIELD_BITS), .OFF_W(KD_OFF_W), .SHIFT(KD_SHIFT), .DIV(KD_DIV))
		u_quant_kd (.clk(clk), .en(cmd.en_recip), .off(off_kd_s3), .q(q_kd));
	jcsp_quant #(.BITS(FIELD_BITS), .OFF_W(T_OFF_W), .SHIFT(T_SHIFT), .DIV(T_DIV))
		u_quant_t (.clk(clk), .en(cmd.en_recip), .off(off_t_s3), .q(q_t));

	assign packed_frame = {
		POS_SLOT_W'(q_p),
		FIELD_SLOT_W'(q_v),
		FIELD_SLOT_W'(q_kp),
		FIELD_SLOT_W'(q_kd),
		FIELD_SLOT_W'(q_t)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_enabled_q <= 1'b0;
			last_frame_q    <= LAST_RST;
		end else begin
			if (cmd.load_mode) motor_enabled_q <= in_s1.enable_request;
			if (cmd.load_cmd) last_frame_q <= packed_frame;
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (cmd.load_mode) begin
			out_q.frame      <= in_s1.enable_request ? ENTER_FRAME : EXIT_FRAME;
			out_q.frame_kind <= in_s1.enable_request ? KIND_ENTER : KIND_EXIT;
			out_q.status     <= STATUS_MODE;
			out_q.last       <= 1'b0;
		end else if (cmd.load_repeat) begin
			out_q.frame      <= last_frame_q;
			out_q.frame_kind <= KIND_COMMAND;
			out_q.status     <= STATUS_MODE;
			out_q.last       <= 1'b1;
		end else if (cmd.load_cmd) begin
			out_q.frame      <= packed_frame;
			out_q.frame_kind <= KIND_COMMAND;
			out_q.status     <= status_s4;
			out_q.last       <= 1'b1;
		end
	end

	assign out_data = out_q;

endmodule
